>>> rtl/rgb_fixed_point_fader_macros.svh
// Assertion macros shared by the fader RTL.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef RGB_FIXED_POINT_FADER_MACROS_SVH
`define RGB_FIXED_POINT_FADER_MACROS_SVH

// Check a property on every rising edge while out of reset.
`define FDR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define FDR_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) trig |=> cond) else $error(msg);

`endif

>>> rtl/fdr_pkg.sv
// Shared types and constants for the RGB fixed-point fader.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fdr_pkg;

	localparam int NumChan  = 3;
	localparam int FracBits = 7;
	localparam int LevelW   = 16;
	localparam int ValW     = 8;
	// (value << 7) minus a signed 16-bit level fits in 18 bits signed; DiffW allows 18
	localparam int DiffW    = 18;
	// magnitude of that difference fits in 17 bits
	localparam int MagW     = 17;
	localparam int ChW      = 2;

	typedef enum logic [1:0] {
		KIND_SET,
		KIND_FADE,
		KIND_TICK,
		KIND_STOP
	} kind_t;

	typedef logic signed [LevelW-1:0] level_t;

	typedef struct packed {
		kind_t           kind;
		logic [ValW-1:0] red_level;
		logic [ValW-1:0] green_level;
		logic [ValW-1:0] blue_level;
		logic [ValW-1:0] fade_steps;
	} in_item_t;

	typedef struct packed {
		logic [ValW-1:0]    red_out;
		logic [ValW-1:0]    green_out;
		logic [ValW-1:0]    blue_out;
		logic [NumChan-1:0] write_mask;
	} out_item_t;

	// Control from the sequencer to the channel register file
	typedef struct packed {
		logic           load;
		logic           clear;
		logic           wr_step;
		logic           tick;
		logic [ChW-1:0] ch;
	} regs_ctrl_t;

endpackage

>>> rtl/rgb_fixed_point_fader.sv
// RGB fader top: sequencer, shared serial divider and channel registers.
// A fade runs the one divider three times, once per channel: start, the quotient bit steps, done.
// One item at a time; the next can be taken the cycle after the result is loaded into the
// output register, and that load waits until any earlier result has been taken.
// Reset clears all levels, steps and the output valid.
`timescale 1ns / 1ps
`include "rgb_fixed_point_fader_macros.svh"

module rgb_fixed_point_fader import fdr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_START,
		S_DIV_WAIT,
		S_TICK,
		S_FINISH
	} state_t;

	state_t             state_q;
	in_item_t           item_q;
	logic [ChW-1:0]     ch_q;
	logic [NumChan-1:0] mask_q;
	out_item_t          out_item_q;
	logic               out_valid_q;

	regs_ctrl_t         ctrl;
	logic [ValW-1:0]    load_val [NumChan];
	level_t             level [NumChan];
	logic [NumChan-1:0] step_nz;

	logic               accept;
	logic               finish;
	logic               div_start;
	logic               div_busy;
	logic               div_done;
	level_t             div_quot;
	logic [ValW-1:0]    val_sel;
	level_t             lvl_sel;
	logic [DiffW-1:0]   diff;
	logic [DiffW-1:0]   mag;
	logic [ValW-1:0]    divisor;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign finish    = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	assign div_start = (state_q == S_DIV_START);

	// Drive the register file
	always_comb begin
		load_val[0]  = in_item.red_level;
		load_val[1]  = in_item.green_level;
		load_val[2]  = in_item.blue_level;
		ctrl.load    = accept && (in_item.kind == KIND_SET);
		ctrl.clear   = accept && (in_item.kind == KIND_STOP);
		ctrl.wr_step = (state_q == S_DIV_WAIT) && div_done;
		ctrl.tick    = (state_q == S_TICK);
		ctrl.ch      = ch_q;
	end

	// Pick the channel under division and form target minus level
	always_comb begin
		unique case (ch_q)
			2'd0: begin
				val_sel = item_q.red_level;
				lvl_sel = level[0];
			end
			2'd1: begin
				val_sel = item_q.green_level;
				lvl_sel = level[1];
			end
			default: begin
				val_sel = item_q.blue_level;
				lvl_sel = level[2];
			end
		endcase
		diff = {{(DiffW-ValW-FracBits){1'b0}}, val_sel, {FracBits{1'b0}}}
			- {{(DiffW-LevelW){lvl_sel[LevelW-1]}}, lvl_sel};
		mag = diff[DiffW-1] ? (~diff + 1'b1) : diff;
		divisor = (item_q.fade_steps == '0) ? ValW'(1) : item_q.fade_steps;
	end

	fdr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag[MagW-1:0]),
		.divisor  (divisor),
		.neg      (diff[DiffW-1]),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot)
	);

	fdr_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.load_val (load_val),
		.step_in  (div_quot),
		.level    (level),
		.step_nz  (step_nz)
	);

	// Sequence the item and hold the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ch_q <= '0;
						unique case (in_item.kind)
							KIND_SET: begin
								mask_q  <= '1;
								state_q <= S_FINISH;
							end
							KIND_FADE: state_q <= S_DIV_START;
							KIND_TICK: state_q <= S_TICK;
							default: begin
								mask_q  <= '0;
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_DIV_START: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_done) begin
						if (ch_q == ChW'(NumChan - 1)) begin
							state_q <= S_TICK;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_DIV_START;
						end
					end
				end
				S_TICK: begin
					mask_q  <= step_nz;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Latch the incoming item and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
		if (finish) begin
			out_item_q.red_out    <= level[0][FracBits+ValW-1:FracBits];
			out_item_q.green_out  <= level[1][FracBits+ValW-1:FracBits];
			out_item_q.blue_out   <= level[2][FracBits+ValW-1:FracBits];
			out_item_q.write_mask <= mask_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`FDR_ASSERT(a_ready_div_idle, in_ready |-> !div_busy, "ready while divider busy")
	`FDR_ASSERT_NEXT(a_accept_blocks, accept, !in_ready, "ready right after an accepted item")
	`FDR_ASSERT(a_done_in_wait, div_done |-> state_q == S_DIV_WAIT, "divider done outside wait")

endmodule

>>> rtl/fdr_div.sv
// Serial restoring divider: 17-bit magnitude by 8-bit divisor, one bit per cycle.
// Applies the sign at the end and wraps the quotient to 16 bits. Uses fdr_pkg.
`timescale 1ns / 1ps
`include "rgb_fixed_point_fader_macros.svh"

module fdr_div import fdr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MagW-1:0]  dividend,
	input  logic [ValW-1:0]  divisor,
	input  logic             neg,
	output logic             busy,
	output logic             done,
	output level_t           quot
);

	localparam int CntW = $clog2(MagW + 1);

	logic [ValW-1:0] rem_q;
	logic [MagW-1:0] dq_q;
	logic [ValW-1:0] div_q;
	logic [CntW-1:0] cnt_q;
	logic            neg_q;
	logic            busy_q;
	logic            done_q;

	logic [ValW:0]   shifted;
	logic [ValW:0]   trial;
	logic            ge;
	logic [LevelW-1:0] qlo;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_q, dq_q[MagW-1]};
		ge      = shifted >= {1'b0, div_q};
		trial   = shifted - {1'b0, div_q};
	end

	// Sequence the bit steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(MagW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold operands, advance remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			div_q <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= ge ? trial[ValW-1:0] : shifted[ValW-1:0];
			dq_q  <= {dq_q[MagW-2:0], ge};
		end
	end

	// Apply the sign; dropping the top bit wraps to 16 bits
	assign qlo  = dq_q[LevelW-1:0];
	assign quot = neg_q ? level_t'(~qlo + 1'b1) : level_t'(qlo);
	assign busy = busy_q;
	assign done = done_q;

	`FDR_ASSERT_NEXT(a_start_busy, start, busy_q, "divider not busy after start")
	`FDR_ASSERT(a_start_idle, start |-> !busy_q, "divider started while busy")

endmodule

>>> rtl/fdr_regs.sv
// Per-channel level and step registers with the tick adders.
// Driven by the sequencer through regs_ctrl_t. Uses fdr_pkg.
`timescale 1ns / 1ps

module fdr_regs import fdr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  regs_ctrl_t         ctrl,
	input  logic [ValW-1:0]    load_val [NumChan],
	input  level_t             step_in,
	output level_t             level [NumChan],
	output logic [NumChan-1:0] step_nz
);

	level_t level_q [NumChan];
	level_t step_q  [NumChan];

	// Flag channels with a live step
	always_comb begin
		for (int i = 0; i < NumChan; i++) begin
			step_nz[i] = |step_q[i];
			level[i]   = level_q[i];
		end
	end

	// Load, clear, write steps and advance levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumChan; i++) begin
				level_q[i] <= '0;
				step_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < NumChan; i++) begin
				if (ctrl.load) begin
					level_q[i] <= level_t'({1'b0, load_val[i], {FracBits{1'b0}}});
				end else if (ctrl.tick && step_nz[i]) begin
					level_q[i] <= level_q[i] + step_q[i];
				end
				if (ctrl.load || ctrl.clear) begin
					step_q[i] <= '0;
				end else if (ctrl.wr_step && ctrl.ch == ChW'(i)) begin
					step_q[i] <= step_in;
				end
			end
		end
	end

endmodule

>>> sim/tb_rgb_fixed_point_fader.sv
// Self-checking testbench for the RGB fixed-point fader: directed and random items.
// Depends on fdr_pkg and rgb_fixed_point_fader; a scoreboard class predicts each result.
`timescale 1ns / 1ps

module tb_rgb_fixed_point_fader;
	import fdr_pkg::*;

	// Track channel levels and steps, and queue the drive levels each item should produce
	class fade_scoreboard;
		level_t    level [NumChan];
		level_t    step [NumChan];
		out_item_t due_levels [$];
		int        errors;
		int        matched;
		int        kind_seen [4];

		function new();
			for (int i = 0; i < NumChan; i++) begin
				level[i] = '0;
				step[i]  = '0;
			end
			errors  = 0;
			matched = 0;
			for (int k = 0; k < 4; k++) kind_seen[k] = 0;
		endfunction

		// Add each nonzero step to its level; return the channels written
		function logic [NumChan-1:0] advance_levels();
			logic [NumChan-1:0] mask;
			mask = '0;
			for (int i = 0; i < NumChan; i++) begin
				if (step[i] != 0) begin
					level[i] = level[i] + step[i];
					mask[i]  = 1'b1;
				end
			end
			return mask;
		endfunction

		// Update the channel state for an accepted item and queue its result
		function void note_item(in_item_t it);
			logic [ValW-1:0]    target [NumChan];
			logic [NumChan-1:0] mask;
			int                 divisor;
			int                 diff;
			int                 quot;
			out_item_t          want;
			target[0] = it.red_level;
			target[1] = it.green_level;
			target[2] = it.blue_level;
			divisor   = (it.fade_steps == 0) ? 1 : int'(it.fade_steps);
			mask      = '0;
			kind_seen[it.kind]++;
			case (it.kind)
				KIND_SET: begin
					for (int i = 0; i < NumChan; i++) begin
						step[i]  = '0;
						level[i] = {1'b0, target[i], 7'b0};
					end
					mask = '1;
				end
				KIND_FADE: begin
					// signed division truncates toward zero; keep the low 16 bits
					for (int i = 0; i < NumChan; i++) begin
						diff    = (int'(target[i]) <<< FracBits) - int'(level[i]);
						quot    = diff / divisor;
						step[i] = quot[LevelW-1:0];
					end
					mask = advance_levels();
				end
				KIND_TICK: mask = advance_levels();
				default: begin
					for (int i = 0; i < NumChan; i++) step[i] = '0;
				end
			endcase
			want.red_out    = level[0][14:7];
			want.green_out  = level[1][14:7];
			want.blue_out   = level[2][14:7];
			want.write_mask = mask;
			due_levels.push_back(want);
		endfunction

		// Compare a result with the oldest queued one
		function void check_result(out_item_t got);
			out_item_t want;
			if (due_levels.size() == 0) begin
				$display("%0t: unexpected result r=%0d g=%0d b=%0d mask=%b", $time,
					got.red_out, got.green_out, got.blue_out, got.write_mask);
				errors++;
				return;
			end
			want = due_levels.pop_front();
			if (got.red_out != want.red_out || got.green_out != want.green_out ||
					got.blue_out != want.blue_out || got.write_mask != want.write_mask) begin
				$display("%0t: mismatch expected r=%0d g=%0d b=%0d mask=%b, actual r=%0d g=%0d b=%0d mask=%b",
					$time, want.red_out, want.green_out, want.blue_out, want.write_mask,
					got.red_out, got.green_out, got.blue_out, got.write_mask);
				errors++;
			end else begin
				matched++;
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	fade_scoreboard sb = new();

	int items_sent = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;
	int unsigned stall_bits = 0;

	rgb_fixed_point_fader dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#50_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Check results and stall the receiver in windows of varying pattern
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(out_item);
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_bits = $urandom;
			stall_left = 32;
		end
		stall_left--;
		stall_bits = {stall_bits[0], stall_bits[31:1]};
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= stall_bits[0];
			2: out_ready <= stall_bits[0] | stall_bits[1];
			default: out_ready <= (stall_left < 6);
		endcase
	end

	// Set the kind, then fill every other field at random
	function automatic in_item_t random_item(kind_t k);
		in_item_t it;
		it.kind        = k;
		it.red_level   = 8'($urandom);
		it.green_level = 8'($urandom);
		it.blue_level  = 8'($urandom);
		it.fade_steps  = 8'($urandom);
		return it;
	endfunction

	function automatic in_item_t make_item(kind_t k, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] n);
		in_item_t it;
		it.kind        = k;
		it.red_level   = r;
		it.green_level = g;
		it.blue_level  = b;
		it.fade_steps  = n;
		return it;
	endfunction

	// Favor the ends of the range
	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly short fades, sometimes long ones
	function automatic logic [7:0] pick_steps();
		if ($urandom_range(0, 3) == 0) return 8'($urandom);
		return 8'($urandom_range(0, 15));
	endfunction

	// Drop valid for a random gap at the end of each burst
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
	endtask

	// Present one item and hold it until accepted
	task automatic send_item(input in_item_t it);
		pace_sender();
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
		items_sent++;
	endtask

	// Mostly set first, then fade and tick for a while; sometimes retarget midway or end with a stop
	task automatic run_scene();
		logic [7:0] n;
		int         ticks;
		if ($urandom_range(0, 3) != 0)
			send_item(make_item(KIND_SET, pick_level(), pick_level(), pick_level(),
				8'($urandom)));
		n = pick_steps();
		send_item(make_item(KIND_FADE, pick_level(), pick_level(), pick_level(), n));
		ticks = $urandom_range(0, (n > 20) ? 20 : n + 2);
		repeat (ticks) begin
			if ($urandom_range(0, 15) == 0)
				send_item(make_item(KIND_FADE, pick_level(), pick_level(), pick_level(),
					pick_steps()));
			else
				send_item(random_item(KIND_TICK));
		end
		if ($urandom_range(0, 2) == 0) send_item(random_item(KIND_STOP));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle state: nothing moves
		send_item(make_item(KIND_TICK, 8'd255, 8'd255, 8'd255, 8'd255));
		send_item(make_item(KIND_STOP, 8'd0, 8'd0, 8'd0, 8'd0));
		// Zero step count with full-scale moves both ways; levels go negative and wrap
		send_item(make_item(KIND_SET, 8'd255, 8'd0, 8'd128, 8'd77));
		send_item(make_item(KIND_FADE, 8'd0, 8'd255, 8'd128, 8'd0));
		send_item(make_item(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
		send_item(make_item(KIND_TICK, 8'd170, 8'd85, 8'd15, 8'd240));
		// Longest fade
		send_item(make_item(KIND_SET, 8'd0, 8'd0, 8'd0, 8'd0));
		send_item(make_item(KIND_FADE, 8'd255, 8'd255, 8'd255, 8'd255));
		repeat (3) send_item(make_item(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
		send_item(make_item(KIND_STOP, 8'd255, 8'd255, 8'd255, 8'd255));
		send_item(make_item(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
		// Quotient wider than 16 bits: start from a wrapped negative level
		send_item(make_item(KIND_SET, 8'd0, 8'd0, 8'd255, 8'd0));
		send_item(make_item(KIND_FADE, 8'd255, 8'd255, 8'd0, 8'd1));
		send_item(make_item(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
		send_item(make_item(KIND_FADE, 8'd255, 8'd0, 8'd255, 8'd1));
		send_item(make_item(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
		send_item(make_item(KIND_FADE, 8'd0, 8'd255, 8'd0, 8'd2));
		send_item(make_item(KIND_STOP, 8'd0, 8'd0, 8'd0, 8'd0));
		send_item(make_item(KIND_SET, 8'd255, 8'd255, 8'd255, 8'd255));

		// Mostly well-formed fade scenes, with loose and out-of-order items mixed in
		while (items_sent < 2020) begin
			if ($urandom_range(0, 9) < 8)
				run_scene();
			else
				send_item(random_item(kind_t'($urandom_range(0, 3))));
		end
		in_valid <= 1'b0;

		while (sb.due_levels.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);

		$display("Sent %0d items: %0d set, %0d fade, %0d tick, %0d stop.", items_sent,
			sb.kind_seen[KIND_SET], sb.kind_seen[KIND_FADE], sb.kind_seen[KIND_TICK],
			sb.kind_seen[KIND_STOP]);
		$display("Checked %0d results, %0d errors.", sb.matched, sb.errors);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
